### hdl/isw_osc_pkg.sv
// Package for the interpolating sine wavetable oscillator.
// Holds register codes, fixed-point limits and the elaboration-time sine helpers.
// No dependencies.
`default_nettype none

package isw_osc_pkg;

  localparam int TABLE_SIZE_DEF = 512;

  // configuration register codes (paddr[3:2])
  localparam logic [1:0] REG_FREQUENCY = 2'd0;
  localparam logic [1:0] REG_STEP_HZ   = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE = 2'd2;

  localparam logic [28:0] FREQ_MIN   = 29'd1966080;
  localparam logic [28:0] FREQ_MAX   = 29'd524288000;
  localparam logic [28:0] FREQ_RESET = 29'd14417920;
  localparam logic [30:0] STEP_HZ_RESET = 31'd699;
  localparam logic [31:0] AMP_RESET  = 32'h3fff_ffff;

  localparam logic [31:0] Q31_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q31_MIN = 32'h8000_0000;
  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

  // floor(n / d) by restoring shift and subtract; elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine magnitude of a first-quadrant angle r (turns scaled by 2^32, r <= 2^30).
  // Used at elaboration only to build the quarter-wave table.
  function automatic logic [31:0] sine_mag(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x = (r * HALF_PI_Q31 + 64'h2000_0000) >> 30;
    x2 = (x * x) >> 31;
    term = x;
    sum = x;
    for (int k = 3; k <= 17; k += 2) begin
      term = udiv64(term * x2, 64'(k - 1) * 64'(k)) >> 31;
      if ((((k - 1) >> 1) & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum > {32'd0, Q31_MAX}) ? Q31_MAX : sum[31:0];
  endfunction

  // floor(p / 2^31) saturated to Q1.31
  function automatic logic [31:0] q31_from_prod(input logic signed [65:0] p);
    logic signed [65:0] q;
    q = p >>> 31;
    if (q > $signed({34'd0, Q31_MAX})) begin
      return Q31_MAX;
    end else if (q < $signed({{34{1'b1}}, Q31_MIN})) begin
      return Q31_MIN;
    end
    return q[31:0];
  endfunction

  function automatic logic [31:0] q31_sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q31_MIN : Q31_MAX;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

### hdl/interpolating_sine_wavetable_osc_unit.sv
// A tick request accepted in S_IDLE runs S_MUL_THIS, S_MUL_NEXT, S_SUM, S_MUL_AMP, S_MUL_STEP,
// S_ROUND, S_ADVANCE and S_WRAP; in_ready is low during this 8-step sequence. S_WRAP holds
// until the output slot is free, then registers the sample. The single 33x33 multiplier is
// used four times per sample. A request with tick low is accepted while idle with no result.
// Reset (rst_n, synchronous, active low): phase to 0, registers to defaults, no result.
// Uses isw_osc_pkg. Quarter-wave sine table is built at elaboration (TABLE_SIZE power of two).
`default_nettype none

module interpolating_sine_wavetable_osc_unit #(
  parameter int TABLE_SIZE = isw_osc_pkg::TABLE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tick requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_tick,
  // samples
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sample,
  // APB-style configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int QUARTER = TABLE_SIZE / 4;
  localparam int PH_W    = IDX_W + 16;
  localparam logic [PH_W-1:0] PHASE_TOP = PH_W'(TABLE_SIZE - 1) << 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_THIS,
    S_MUL_NEXT,
    S_SUM,
    S_MUL_AMP,
    S_MUL_STEP,
    S_ROUND,
    S_ADVANCE,
    S_WRAP
  } state_t;

  function automatic logic [QUARTER:0][31:0] build_qtab();
    logic [QUARTER:0][31:0] t;
    for (int j = 0; j <= QUARTER; j++) begin
      t[j] = isw_osc_pkg::sine_mag(64'(j) << (32 - IDX_W));
    end
    return t;
  endfunction

  localparam logic [QUARTER:0][31:0] QTAB = build_qtab();

  // full-wave entry from the quarter table: mirror odd quadrants, negate the second half
  function automatic logic [31:0] tab_word(input logic [IDX_W-1:0] idx);
    logic [IDX_W-2:0] j;
    logic [31:0] m;
    j = idx[IDX_W-2] ? ((IDX_W-1)'(QUARTER) - {1'b0, idx[IDX_W-3:0]})
                     : {1'b0, idx[IDX_W-3:0]};
    m = QTAB[j];
    return idx[IDX_W-1] ? (32'd0 - m) : m;
  endfunction

  state_t            state_r, state_nxt;
  logic [28:0]       freq_r, freq_nxt;
  logic [30:0]       sph_r, sph_nxt;
  logic [31:0]       amp_r, amp_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [IDX_W-1:0]  tab_idx_r, tab_idx_nxt;
  logic [31:0]       ent_r, ent_nxt;
  logic [28:0]       hz_r, hz_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       res_r, res_nxt;
  logic [PH_W-1:0]   step_r, step_nxt;
  logic [PH_W:0]     sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_sample_r, out_sample_nxt;

  logic              cfg_wr;
  logic              slot_free;
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       rd_word;
  logic [31:0]       w_next;
  logic [31:0]       w_this;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [44:0]       rounded;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite;
  assign slot_free  = !out_valid_r || out_ready;

  always_comb begin
    unique case (paddr[3:2])
      isw_osc_pkg::REG_FREQUENCY: prdata = {3'd0, freq_r};
      isw_osc_pkg::REG_STEP_HZ:   prdata = {1'b0, sph_r};
      isw_osc_pkg::REG_AMPLITUDE: prdata = amp_r;
      default:                    prdata = 32'd0;
    endcase
  end

  // single table read port: current entry at accept, neighbor afterwards
  assign rd_idx  = (state_r == S_IDLE) ? phase_r[PH_W-1:16] : tab_idx_r;
  assign rd_word = tab_word(rd_idx);

  assign w_next = {1'b0, phase_r[15:0], 15'd0};
  assign w_this = isw_osc_pkg::Q31_MAX - w_next;

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MUL_THIS: begin
        mul_a = {ent_r[31], ent_r};
        mul_b = {1'b0, w_this};
      end
      S_MUL_NEXT: begin
        mul_a = {ent_r[31], ent_r};
        mul_b = {1'b0, w_next};
      end
      S_MUL_AMP: begin
        mul_a = {amp_r[31], amp_r};
        mul_b = {acc_r[31], acc_r};
      end
      S_MUL_STEP: begin
        mul_a = {4'd0, hz_r};
        mul_b = {2'd0, sph_r};
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign rounded = {1'b0, prod_r[59:16]} + 45'(prod_r[15]);

  always_comb begin
    state_nxt      = state_r;
    freq_nxt       = freq_r;
    sph_nxt        = sph_r;
    amp_nxt        = amp_r;
    phase_nxt      = phase_r;
    tab_idx_nxt    = tab_idx_r;
    ent_nxt        = ent_r;
    hz_nxt         = hz_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    step_nxt       = step_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      unique case (paddr[3:2])
        isw_osc_pkg::REG_FREQUENCY: freq_nxt = pwdata[28:0];
        isw_osc_pkg::REG_STEP_HZ:   sph_nxt  = pwdata[30:0];
        isw_osc_pkg::REG_AMPLITUDE: amp_nxt  = pwdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_tick) begin
          ent_nxt     = rd_word;
          tab_idx_nxt = phase_r[PH_W-1:16] + IDX_W'(1);
          state_nxt   = S_MUL_THIS;
        end
      end
      S_MUL_THIS: begin
        prod_nxt = mul_p;
        ent_nxt  = rd_word;
        if (freq_r < isw_osc_pkg::FREQ_MIN) begin
          hz_nxt = isw_osc_pkg::FREQ_MIN;
        end else if (freq_r > isw_osc_pkg::FREQ_MAX) begin
          hz_nxt = isw_osc_pkg::FREQ_MAX;
        end else begin
          hz_nxt = freq_r;
        end
        state_nxt = S_MUL_NEXT;
      end
      S_MUL_NEXT: begin
        acc_nxt   = isw_osc_pkg::q31_from_prod(prod_r);
        prod_nxt  = mul_p;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        acc_nxt   = isw_osc_pkg::q31_sat_add(acc_r, isw_osc_pkg::q31_from_prod(prod_r));
        state_nxt = S_MUL_AMP;
      end
      S_MUL_AMP: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        res_nxt   = isw_osc_pkg::q31_from_prod(prod_r);
        prod_nxt  = mul_p;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        step_nxt  = (rounded > 45'(PHASE_TOP)) ? PHASE_TOP : rounded[PH_W-1:0];
        state_nxt = S_ADVANCE;
      end
      S_ADVANCE: begin
        sum_nxt   = {1'b0, phase_r} + {1'b0, step_r};
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        // hold here until the output register can take the sample
        if (slot_free) begin
          phase_nxt      = (sum_r > {1'b0, PHASE_TOP}) ? (sum_r[PH_W-1:0] - PHASE_TOP)
                                                      : sum_r[PH_W-1:0];
          out_sample_nxt = res_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      freq_r      <= isw_osc_pkg::FREQ_RESET;
      sph_r       <= isw_osc_pkg::STEP_HZ_RESET;
      amp_r       <= isw_osc_pkg::AMP_RESET;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      freq_r      <= freq_nxt;
      sph_r       <= sph_nxt;
      amp_r       <= amp_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tab_idx_r    <= tab_idx_nxt;
    ent_r        <= ent_nxt;
    hz_r         <= hz_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    res_r        <= res_nxt;
    step_r       <= step_nxt;
    sum_r        <= sum_nxt;
    out_sample_r <= out_sample_nxt;
  end

`ifndef SYNTHESIS
  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_TOP)
    else $error("phase above wrap point");

  a_idle_tick_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_tick) |=> (state_r == S_IDLE) && $stable(phase_r))
    else $error("tick-low request started work or moved phase");

  a_result_from_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WRAP))
    else $error("sample issued outside wrap step");

  a_phase_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WRAP) |=> $stable(phase_r))
    else $error("phase moved mid-sequence");
`endif

endmodule

`default_nettype wire
